// ===== sv/wfbs_pkg.sv =====
// ----------------------------------------------------------------------------
// wfbs_pkg
// Shared sizes, codes and entry formats of the warp formation scheduler.
// ----------------------------------------------------------------------------
package wfbs_pkg;

   localparam int NUM_BLOCKS        = 8;
   localparam int THREADS_PER_BLOCK = 256;
   localparam int RESUME_BITS       = 16;
   localparam int MAX_GROUP         = 64;

   localparam int THR_W   = 8;                           // thread field width
   localparam int IDX_W   = $clog2(THREADS_PER_BLOCK);   // list slot index
   localparam int CNT_W   = IDX_W + 1;                   // list fill count
   localparam int BID_W   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int GRP_W   = 7;                           // group size / member count
   localparam int MBA_W   = $clog2(MAX_GROUP);           // member buffer address
   localparam int WAIT_W  = 12;                          // waiting total
   localparam int ENT_DEPTH = 2 * NUM_BLOCKS * THREADS_PER_BLOCK;

   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_RETURN = 2'd1,
      ACT_FORM   = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      EX_FALLTHROUGH = 3'd0,
      EX_BRANCH      = 3'd1,
      EX_TAILCALL    = 3'd2,
      EX_CALL        = 3'd3,
      EX_BARRIER     = 3'd4,
      EX_EXIT        = 3'd5,
      EX_EXIT_OTHER  = 3'd6,
      EX_UNDEFINED   = 3'd7
   } exit_type;

   typedef enum logic [2:0] {
      ST_MEMBER      = 3'd0,
      ST_WAITING     = 3'd1,
      ST_DONE        = 3'd2,
      ST_UNSUPPORTED = 3'd3,
      ST_FULL        = 3'd4
   } status_type;

   // one list slot
   typedef struct packed {
      logic [RESUME_BITS-1:0] resume;
      logic [THR_W-1:0]       thread;
   } entry_type;

   // one gathered warp member
   typedef struct packed {
      logic [BID_W-1:0] blk;
      logic [THR_W-1:0] thread;
   } member_type;

   // largest power of two not above n (n >= 1)
   function automatic logic [GRP_W-1:0] pow2_floor(input logic [GRP_W-1:0] n);
      logic [GRP_W-1:0] r;
      r = '0;
      for (int j = 0; j < GRP_W; j++) begin
         if (n[j]) begin
            r = GRP_W'(1) << j;
         end
      end
      return r;
   endfunction

endpackage

// ===== sv/wfbs_ram.sv =====
// ----------------------------------------------------------------------------
// wfbs_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wfbs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end

endmodule

// ===== sv/warp_formation_barrier_scheduler.sv =====
// ----------------------------------------------------------------------------
// warp_formation_barrier_scheduler
// Per-block ready and barrier lists with warp gathering and barrier release.
// ----------------------------------------------------------------------------
// Works on one request word at a time. Add and return words go through a push
// state and an acknowledge state that waits on the response side. A form word
// runs the barrier release, then the totals, then scans the ready list of each
// block in turn, sizes the warp, pushes back the members above the power of
// two and returns the rest, or answers with a status word if no list is ready;
// the scan is paced by the single read port of the list RAM, which delivers
// one entry per cycle. A barrier release swaps the two banks of a block
// instead of copying, so all blocks are released together in the release
// state. No clearing pass is needed after reset: list slots are only read
// below the fill counts.
module warp_formation_barrier_scheduler (
   input  logic        clock,
   input  logic        reset,
   // request: tdata = block_index[2:0], thread_index[10:3],
   //          resume_point[26:11], exit_kind[29:27], zero pad
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic [1:0]  req_tuser,   // action
   // response: tdata = member_block[2:0], member_thread[10:3],
   //           warp_resume_point[26:11], waiting_total[38:27], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   output logic [2:0]  rsp_tuser,   // status
   output logic        rsp_tlast,   // last_member
   // group size register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_PUSH, S_ACK, S_REL, S_SUM, S_NONE, S_SCAN,
      S_PCALC, S_TRIM, S_TRIMW, S_MRD, S_MLD
   } state_type;

   localparam int NB = wfbs_pkg::NUM_BLOCKS;

   state_type state_ff, state_in;

   // latched request
   logic [wfbs_pkg::BID_W-1:0]       blk_ff, blk_in;
   logic [wfbs_pkg::THR_W-1:0]       thr_ff, thr_in;
   logic [wfbs_pkg::RESUME_BITS-1:0] rq_rp_ff, rq_rp_in;
   wfbs_pkg::exit_type               ek_ff, ek_in;
   wfbs_pkg::action_type             act_ff, act_in;
   wfbs_pkg::status_type             st_ff, st_in;

   logic [wfbs_pkg::GRP_W-1:0] gs_ff, gs_in;

   // per-block list control
   logic                       bank_ff [NB];
   logic                       bank_in [NB];
   logic [wfbs_pkg::CNT_W-1:0] rcnt_ff [NB];
   logic [wfbs_pkg::CNT_W-1:0] rcnt_in [NB];
   logic [wfbs_pkg::CNT_W-1:0] bcnt_ff [NB];
   logic [wfbs_pkg::CNT_W-1:0] bcnt_in [NB];

   // scan and emit control
   logic [wfbs_pkg::BID_W-1:0]       b_ff, b_in;
   logic [wfbs_pkg::CNT_W-1:0]       i_ff, i_in;
   logic [wfbs_pkg::CNT_W-1:0]       w_ff, w_in;
   logic [wfbs_pkg::GRP_W-1:0]       n_ff, n_in;
   logic                             pend_ff, pend_in;
   logic [wfbs_pkg::RESUME_BITS-1:0] rp_ff, rp_in;
   logic [wfbs_pkg::GRP_W-1:0]       p_ff, p_in;
   logic [wfbs_pkg::GRP_W-1:0]       k_ff, k_in;
   logic [wfbs_pkg::WAIT_W-1:0]      wt_ff, wt_in;

   // response register
   logic                             rv_ff, rv_in;
   wfbs_pkg::status_type             rst_ff, rst_in;
   logic [wfbs_pkg::BID_W-1:0]       rblk_ff, rblk_in;
   logic [wfbs_pkg::THR_W-1:0]       rthr_ff, rthr_in;
   logic [wfbs_pkg::RESUME_BITS-1:0] rrp_ff, rrp_in;
   logic                             rlast_ff, rlast_in;
   logic [wfbs_pkg::WAIT_W-1:0]      rwt_ff, rwt_in;

   // memories
   logic                                 ent_we;
   logic [$clog2(wfbs_pkg::ENT_DEPTH)-1:0] ent_waddr, ent_raddr;
   wfbs_pkg::entry_type                  ent_wdata, ent_rdata;
   logic                                 mb_we;
   logic [wfbs_pkg::MBA_W-1:0]           mb_waddr, mb_raddr;
   wfbs_pkg::member_type                 mb_wdata, mb_rdata;

   // misc
   logic [wfbs_pkg::BID_W-1:0]  cix;
   logic [wfbs_pkg::CNT_W-1:0]  cur_r, cur_b;
   logic                        cur_bank;
   logic [wfbs_pkg::GRP_W-1:0]  lim;
   logic                        out_free;
   logic                        req_acc;
   logic                        issue, take;
   logic [wfbs_pkg::WAIT_W-1:0] wsum;
   logic                        any_ready;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rv_ff || rsp_tready;

   assign rsp_tvalid = rv_ff;
   assign rsp_tuser  = rst_ff;
   assign rsp_tlast  = rlast_ff;
   assign rsp_tdata  = {1'b0, rwt_ff, rrp_ff, rthr_ff, rblk_ff};

   // effective group limit, clamped to 1..MAX_GROUP
   always_comb begin
      if (gs_ff == '0) begin
         lim = wfbs_pkg::GRP_W'(1);
      end else if (gs_ff > wfbs_pkg::GRP_W'(wfbs_pkg::MAX_GROUP)) begin
         lim = wfbs_pkg::GRP_W'(wfbs_pkg::MAX_GROUP);
      end else begin
         lim = gs_ff;
      end
   end

   // one count/bank read port, selected by state
   always_comb begin
      unique case (state_ff)
         S_PUSH:  cix = blk_ff;
         S_TRIMW: cix = mb_rdata.blk;
         default: cix = b_ff;
      endcase
   end
   assign cur_r    = rcnt_ff[cix];
   assign cur_b    = bcnt_ff[cix];
   assign cur_bank = bank_ff[cix];

   // totals after release
   always_comb begin
      wsum      = '0;
      any_ready = 1'b0;
      for (int j = 0; j < NB; j++) begin
         wsum      = wsum + wfbs_pkg::WAIT_W'(bcnt_ff[j]);
         any_ready = any_ready | (rcnt_ff[j] != '0);
      end
   end

   // scan: read slot i of the ready bank of block b
   assign ent_raddr = {b_ff, cur_bank, i_ff[wfbs_pkg::IDX_W-1:0]};
   assign issue     = (state_ff == S_SCAN) && (i_ff < cur_r);
   assign take      = (n_ff < lim) && ((n_ff == '0) || (ent_rdata.resume == rp_ff));

   // next-state logic
   always_comb begin
      state_in = state_ff;
      blk_in   = blk_ff;
      thr_in   = thr_ff;
      rq_rp_in = rq_rp_ff;
      ek_in    = ek_ff;
      act_in   = act_ff;
      st_in    = st_ff;
      gs_in    = gs_ff;
      bank_in  = bank_ff;
      rcnt_in  = rcnt_ff;
      bcnt_in  = bcnt_ff;
      b_in     = b_ff;
      i_in     = i_ff;
      w_in     = w_ff;
      n_in     = n_ff;
      pend_in  = 1'b0;
      rp_in    = rp_ff;
      p_in     = p_ff;
      k_in     = k_ff;
      wt_in    = wt_ff;
      rv_in    = rv_ff && !rsp_tready;
      rst_in   = rst_ff;
      rblk_in  = rblk_ff;
      rthr_in  = rthr_ff;
      rrp_in   = rrp_ff;
      rlast_in = rlast_ff;
      rwt_in   = rwt_ff;
      ent_we    = 1'b0;
      ent_waddr = '0;
      ent_wdata = '0;
      mb_we     = 1'b0;
      mb_waddr  = n_ff[wfbs_pkg::MBA_W-1:0];
      mb_wdata  = '0;
      mb_raddr  = k_ff[wfbs_pkg::MBA_W-1:0];

      if (csr_valid && csr_ready) begin
         gs_in = csr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               act_in   = wfbs_pkg::action_type'(req_tuser);
               blk_in   = wfbs_pkg::BID_W'(req_tdata[2:0] % wfbs_pkg::NUM_BLOCKS);
               thr_in   = req_tdata[10:3];
               rq_rp_in = req_tdata[26:11];
               ek_in    = wfbs_pkg::exit_type'(req_tdata[29:27]);
               priority case (wfbs_pkg::action_type'(req_tuser))
                  wfbs_pkg::ACT_FORM: state_in = S_REL;
                  wfbs_pkg::ACT_NONE: state_in = S_IDLE;
                  default:            state_in = S_PUSH;
               endcase
            end
         end

         // route the thread: append it to the ready or barrier list, or only acknowledge it
         S_PUSH: begin
            st_in    = wfbs_pkg::ST_MEMBER;
            state_in = S_ACK;
            ent_wdata = {rq_rp_ff, thr_ff};
            if (act_ff == wfbs_pkg::ACT_ADD || ek_ff == wfbs_pkg::EX_FALLTHROUGH ||
                ek_ff == wfbs_pkg::EX_BRANCH) begin
               if (cur_r == wfbs_pkg::CNT_W'(wfbs_pkg::THREADS_PER_BLOCK)) begin
                  st_in = wfbs_pkg::ST_FULL;
               end else begin
                  ent_we    = 1'b1;
                  ent_waddr = {blk_ff, cur_bank, cur_r[wfbs_pkg::IDX_W-1:0]};
                  rcnt_in[blk_ff] = cur_r + 1'b1;
               end
            end else if (ek_ff == wfbs_pkg::EX_BARRIER) begin
               if (cur_b == wfbs_pkg::CNT_W'(wfbs_pkg::THREADS_PER_BLOCK)) begin
                  st_in = wfbs_pkg::ST_FULL;
               end else begin
                  ent_we    = 1'b1;
                  ent_waddr = {blk_ff, !cur_bank, cur_b[wfbs_pkg::IDX_W-1:0]};
                  bcnt_in[blk_ff] = cur_b + 1'b1;
               end
            end else if (ek_ff == wfbs_pkg::EX_EXIT || ek_ff == wfbs_pkg::EX_EXIT_OTHER) begin
               st_in = wfbs_pkg::ST_MEMBER;
            end else begin
               st_in = wfbs_pkg::ST_UNSUPPORTED;
            end
         end

         S_ACK: begin
            if (out_free) begin
               rv_in    = 1'b1;
               rst_in   = st_ff;
               rblk_in  = '0;
               rthr_in  = '0;
               rrp_in   = '0;
               rlast_in = 1'b1;
               rwt_in   = '0;
               state_in = S_IDLE;
            end
         end

         // barrier release: swap banks where ready is empty
         S_REL: begin
            for (int j = 0; j < NB; j++) begin
               if (bcnt_ff[j] != '0 && rcnt_ff[j] == '0) begin
                  bank_in[j] = !bank_ff[j];
                  rcnt_in[j] = bcnt_ff[j];
                  bcnt_in[j] = '0;
               end
            end
            state_in = S_SUM;
         end

         S_SUM: begin
            wt_in = wsum;
            b_in  = '0;
            i_in  = '0;
            w_in  = '0;
            n_in  = '0;
            state_in = any_ready ? S_SCAN : S_NONE;
         end

         S_NONE: begin
            if (out_free) begin
               rv_in    = 1'b1;
               rst_in   = (wt_ff != '0) ? wfbs_pkg::ST_WAITING : wfbs_pkg::ST_DONE;
               rblk_in  = '0;
               rthr_in  = '0;
               rrp_in   = '0;
               rlast_in = 1'b1;
               rwt_in   = wt_ff;
               state_in = S_IDLE;
            end
         end

         // stream the ready list: gather members, compact the rest in place
         S_SCAN: begin
            if (issue) begin
               pend_in = 1'b1;
               i_in    = i_ff + 1'b1;
            end
            if (pend_ff) begin
               if (take) begin
                  rp_in    = ent_rdata.resume;
                  mb_we    = 1'b1;
                  mb_wdata = {b_ff, ent_rdata.thread};
                  n_in     = n_ff + 1'b1;
               end else begin
                  ent_we    = 1'b1;
                  ent_waddr = {b_ff, cur_bank, w_ff[wfbs_pkg::IDX_W-1:0]};
                  ent_wdata = ent_rdata;
                  w_in      = w_ff + 1'b1;
               end
            end
            if (!issue && !pend_ff) begin
               rcnt_in[b_ff] = w_ff;
               if (b_ff == wfbs_pkg::BID_W'(NB - 1) || n_ff >= lim) begin
                  state_in = S_PCALC;
               end else begin
                  b_in = b_ff + 1'b1;
                  i_in = '0;
                  w_in = '0;
               end
            end
         end

         S_PCALC: begin
            p_in     = wfbs_pkg::pow2_floor(n_ff);
            k_in     = n_ff;
            state_in = S_TRIM;
         end

         // push back members above the power of two, last first
         S_TRIM: begin
            if (k_ff > p_ff) begin
               mb_raddr = wfbs_pkg::MBA_W'(k_ff - 1'b1);
               state_in = S_TRIMW;
            end else begin
               k_in     = '0;
               state_in = S_MRD;
            end
         end

         S_TRIMW: begin
            ent_we    = 1'b1;
            ent_waddr = {mb_rdata.blk, cur_bank, cur_r[wfbs_pkg::IDX_W-1:0]};
            ent_wdata = {rp_ff, mb_rdata.thread};
            rcnt_in[mb_rdata.blk] = cur_r + 1'b1;
            k_in     = k_ff - 1'b1;
            state_in = S_TRIM;
         end

         S_MRD: begin
            state_in = S_MLD;
         end

         // emit member k
         S_MLD: begin
            if (out_free) begin
               rv_in    = 1'b1;
               rst_in   = wfbs_pkg::ST_MEMBER;
               rblk_in  = mb_rdata.blk;
               rthr_in  = mb_rdata.thread;
               rrp_in   = rp_ff;
               rlast_in = (k_ff + 1'b1 == p_ff);
               rwt_in   = wt_ff;
               k_in     = k_ff + 1'b1;
               state_in = (k_ff + 1'b1 == p_ff) ? S_IDLE : S_MRD;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         gs_ff    <= wfbs_pkg::GRP_W'(32);
         pend_ff  <= 1'b0;
         rv_ff    <= 1'b0;
         for (int j = 0; j < NB; j++) begin
            bank_ff[j] <= 1'b0;
            rcnt_ff[j] <= '0;
            bcnt_ff[j] <= '0;
         end
      end else begin
         state_ff <= state_in;
         gs_ff    <= gs_in;
         pend_ff  <= pend_in;
         rv_ff    <= rv_in;
         bank_ff  <= bank_in;
         rcnt_ff  <= rcnt_in;
         bcnt_ff  <= bcnt_in;
      end
      blk_ff   <= blk_in;
      thr_ff   <= thr_in;
      rq_rp_ff <= rq_rp_in;
      ek_ff    <= ek_in;
      act_ff   <= act_in;
      st_ff    <= st_in;
      b_ff     <= b_in;
      i_ff     <= i_in;
      w_ff     <= w_in;
      n_ff     <= n_in;
      rp_ff    <= rp_in;
      p_ff     <= p_in;
      k_ff     <= k_in;
      wt_ff    <= wt_in;
      rst_ff   <= rst_in;
      rblk_ff  <= rblk_in;
      rthr_ff  <= rthr_in;
      rrp_ff   <= rrp_in;
      rlast_ff <= rlast_in;
      rwt_ff   <= rwt_in;
   end

   // list slots, two banks per block
   wfbs_ram #(
      .WIDTH ($bits(wfbs_pkg::entry_type)),
      .DEPTH (wfbs_pkg::ENT_DEPTH)
   ) u_entries (
      .clock (clock),
      .we    (ent_we),
      .waddr (ent_waddr),
      .wdata (ent_wdata),
      .raddr (ent_raddr),
      .rdata (ent_rdata)
   );

   // gathered warp members
   wfbs_ram #(
      .WIDTH ($bits(wfbs_pkg::member_type)),
      .DEPTH (wfbs_pkg::MAX_GROUP)
   ) u_members (
      .clock (clock),
      .we    (mb_we),
      .waddr (mb_waddr),
      .wdata (mb_wdata),
      .raddr (mb_raddr),
      .rdata (mb_rdata)
   );

   // compaction never overtakes the read pointer
   a_compact: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> w_ff <= i_ff)
      else $error("compaction write passed scan read");

   // gathered count stays within the limit
   a_limit: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> n_ff <= lim)
      else $error("warp exceeded group limit");

   // a list count never exceeds its capacity
   a_count: assert property (@(posedge clock) disable iff (reset)
      cur_r <= wfbs_pkg::CNT_W'(wfbs_pkg::THREADS_PER_BLOCK) &&
      cur_b <= wfbs_pkg::CNT_W'(wfbs_pkg::THREADS_PER_BLOCK))
      else $error("list count overflow");

   // the final member word returns the block to idle
   a_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MLD && out_free && rlast_in) |=> state_ff == S_IDLE)
      else $error("last member without return to idle");

   // a trim leaves a nonzero power of two to emit
   a_pow2: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MRD |-> $onehot(p_ff))
      else $error("emit count not a power of two");

endmodule
